[design/ppot_pkg.sv]
// Shared types, codes and sizing constants for the protected page owner table.
package ppot_pkg;

    localparam int REGION_PAGES = 256;
    localparam int PAGE_BITS    = 12;
    localparam int OWNER_COUNT  = 16;

    localparam int ADDR_W   = 64;
    localparam int OWNER_W  = 5;
    localparam int HANDLE_W = 48;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;

    localparam int PAGE_IDX_W = (REGION_PAGES > 1) ? $clog2(REGION_PAGES) : 1;

    // Byte span of the region, one bit wider than an address.
    localparam logic [ADDR_W:0] REGION_SPAN = (ADDR_W + 1)'(REGION_PAGES) << PAGE_BITS;

    localparam logic signed [OWNER_W-1:0] OWNER_NONE = -5'sd1;

    localparam logic [KIND_W-1:0] KIND_REGISTER   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DEREGISTER = 3'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY_SECS = 3'd2;
    localparam logic [KIND_W-1:0] KIND_GET_HANDLE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_GET_OWNER  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_UPD_HANDLE = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OUTSIDE      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY        = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_HANDLE_OWNER = 2'd3;

    typedef struct packed {
        logic signed [OWNER_W-1:0] owner;
        logic [HANDLE_W-1:0]       handle;
        logic                      secs;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{owner: OWNER_NONE, handle: '0, secs: 1'b0};

    typedef struct packed {
        logic                  in_region;
        logic [PAGE_IDX_W-1:0] page;
    } region_t;

    typedef struct packed {
        logic                  en;
        logic [PAGE_IDX_W-1:0] addr;
        entry_t                data;
    } table_wr_t;

endpackage

[design/protected_page_owner_table_top.sv]
// Top level of the protected page owner table: request sequencing and result formation.
// A request's region check and table read are registered when it is taken; the entry update
// and result register follow in the update cycle. s_tready is low outside the idle state, so
// one request is handled at a time and a new one is not taken until the result is registered.
// A result waiting on m_tready holds the block in its update cycle.
// Reset (rst_n low, asynchronous) clears region_base and marks every page entry empty at once.
module protected_page_owner_table_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [63:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata: addr[63:0], owner_in[68:64], handle_in[116:69], secs_in[117], zero pad
    input  logic [119:0] s_tdata,
    // s_tuser: kind[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata: status[1:0], overwrote[2], owner_out[7:3], handle_out[55:8], secs_out[56], zero pad
    output logic [63:0]  m_tdata
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic [ppot_pkg::ADDR_W-1:0] region_base_reg;
    logic out_valid_reg;
    logic [63:0] out_data_reg;

    logic [ppot_pkg::KIND_W-1:0]       kind_reg;
    logic signed [ppot_pkg::OWNER_W-1:0] owner_reg;
    logic [ppot_pkg::HANDLE_W-1:0]     handle_reg;
    logic                              secs_reg;
    ppot_pkg::region_t                 region_reg;

    ppot_pkg::region_t   region;
    ppot_pkg::entry_t    entry;
    ppot_pkg::table_wr_t wr;
    logic accept;
    logic advance;
    logic live;

    logic [ppot_pkg::STATUS_W-1:0]       status;
    logic                                overwrote;
    logic signed [ppot_pkg::OWNER_W-1:0] owner_out;
    logic [ppot_pkg::HANDLE_W-1:0]       handle_out;
    logic                                secs_out;
    logic                                wr_en;
    ppot_pkg::entry_t                    wr_data;

    ppot_region u_region (
        .addr        (s_tdata[63:0]),
        .region_base (region_base_reg),
        .region      (region)
    );

    ppot_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (region.page),
        .rd_data (entry),
        .wr      (wr)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    // The update cycle completes once the output register is free or being drained.
    assign advance  = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (advance)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign live = (entry.owner != ppot_pkg::OWNER_NONE) || (entry.handle != '0);

    always_comb
    begin
        status     = ppot_pkg::STATUS_OK;
        overwrote  = 1'b0;
        owner_out  = ppot_pkg::OWNER_NONE;
        handle_out = '0;
        secs_out   = 1'b0;
        wr_en      = 1'b0;
        wr_data    = entry;
        case (kind_reg)
            ppot_pkg::KIND_REGISTER:
            begin
                if ((handle_reg != '0) && (owner_reg != ppot_pkg::OWNER_NONE))
                begin
                    status = ppot_pkg::STATUS_HANDLE_OWNER;
                end
                else if (!region_reg.in_region)
                begin
                    status = ppot_pkg::STATUS_OUTSIDE;
                end
                else
                begin
                    overwrote      = live;
                    wr_en          = 1'b1;
                    wr_data.owner  = owner_reg;
                    wr_data.handle = handle_reg;
                    wr_data.secs   = secs_reg;
                end
            end
            ppot_pkg::KIND_DEREGISTER:
            begin
                if (!region_reg.in_region)
                begin
                    status = ppot_pkg::STATUS_OUTSIDE;
                end
                else if (!live)
                begin
                    status = ppot_pkg::STATUS_EMPTY;
                end
                else
                begin
                    // The secs flag survives a deregister.
                    wr_en          = 1'b1;
                    wr_data.owner  = ppot_pkg::OWNER_NONE;
                    wr_data.handle = '0;
                end
            end
            ppot_pkg::KIND_QUERY_SECS:
            begin
                if (!region_reg.in_region)
                begin
                    status = ppot_pkg::STATUS_OUTSIDE;
                end
                else if (!live)
                begin
                    status = ppot_pkg::STATUS_EMPTY;
                end
                else
                begin
                    secs_out = entry.secs;
                end
            end
            ppot_pkg::KIND_GET_HANDLE:
            begin
                if (!region_reg.in_region)
                begin
                    status = ppot_pkg::STATUS_OUTSIDE;
                end
                else if (entry.handle == '0)
                begin
                    status = ppot_pkg::STATUS_EMPTY;
                end
                else
                begin
                    handle_out = entry.handle;
                end
            end
            ppot_pkg::KIND_GET_OWNER:
            begin
                if (!region_reg.in_region)
                begin
                    status = ppot_pkg::STATUS_OUTSIDE;
                end
                else
                begin
                    owner_out = entry.owner;
                end
            end
            ppot_pkg::KIND_UPD_HANDLE:
            begin
                if (!region_reg.in_region)
                begin
                    status = ppot_pkg::STATUS_OUTSIDE;
                end
                else if (entry.handle == '0)
                begin
                    status = ppot_pkg::STATUS_EMPTY;
                end
                else
                begin
                    wr_en          = 1'b1;
                    wr_data.handle = handle_reg;
                end
            end
            default:
            begin
                status = ppot_pkg::STATUS_OK;
            end
        endcase
    end

    assign wr.en   = wr_en && advance;
    assign wr.addr = region_reg.page;
    assign wr.data = wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            region_base_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                region_base_reg <= cfg_wdata;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= s_tuser;
            owner_reg  <= s_tdata[68:64];
            handle_reg <= s_tdata[116:69];
            secs_reg   <= s_tdata[117];
            region_reg <= region;
        end
        if (advance)
        begin
            out_data_reg <= {7'd0, secs_out, handle_out, owner_out, overwrote, status};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[design/ppot_region.sv]
// Region bounds check and page index extraction for one byte address.
module ppot_region (
    input  logic [ppot_pkg::ADDR_W-1:0] addr,
    input  logic [ppot_pkg::ADDR_W-1:0] region_base,
    output ppot_pkg::region_t           region
);

    logic [ppot_pkg::ADDR_W:0] diff;

    // The top bit of the difference is the borrow, set when addr lies below the base.
    assign diff = {1'b0, addr} - {1'b0, region_base};

    assign region.in_region = !diff[ppot_pkg::ADDR_W] && (diff < ppot_pkg::REGION_SPAN);
    assign region.page      = diff[ppot_pkg::PAGE_BITS +: ppot_pkg::PAGE_IDX_W];

endmodule

[design/ppot_table.sv]
// Page entry memory with per-entry valid bits; an unwritten entry reads as the reset entry.
module ppot_table (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rd_en,
    input  logic [ppot_pkg::PAGE_IDX_W-1:0]   rd_addr,
    output ppot_pkg::entry_t                  rd_data,
    input  ppot_pkg::table_wr_t               wr
);

    ppot_pkg::entry_t mem [ppot_pkg::REGION_PAGES];
    logic [ppot_pkg::REGION_PAGES-1:0] valid_reg;
    ppot_pkg::entry_t rd_word_reg;
    logic rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : ppot_pkg::ENTRY_RESET;

endmodule
